@@ rtl/core/b64_pkg.sv @@
// Shared types, constants and the character map of the Base64 stream decoder.
package b64_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LEN  = 2'd2
    } t_status;

    // Up to three results that one item causes, drained in order
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            bval;
        logic            fin;
        t_status         status;
    } t_group;

    // Map one character: bit 6 set when it belongs to the alphabet
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [6:0] res;
        res = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            res = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            res = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            res = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            res = {1'b1, 6'd63};
        end
        return res;
    endfunction

endpackage

@@ rtl/core/b64_if.sv @@
// Handshake interfaces for the character input and the byte output channels.
interface b64_in_if;
    import b64_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface b64_out_if;
    import b64_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic [1:0] status;

    modport source (output valid, output out_byte, output byte_valid, output out_last,
                    output status, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input out_last,
                  input status, output ready);
endinterface

@@ rtl/core/b64_dec.sv @@
// Input register, decode state and per-item result group builder.
module b64_dec
    import b64_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    b64_in_if.sink       i_char_if,
    input  logic         i_take_ok,
    output logic         o_load,
    output t_group       o_group
);

    logic        r_s1_valid;
    logic [7:0]  r_char;
    logic        r_last;

    logic [17:0] r_sext, n_sext;
    logic [1:0]  r_gcnt, n_gcnt;
    logic [1:0]  r_len, n_len;
    logic        r_pad, n_pad;
    logic        r_err, n_err;

    logic        move;
    logic [6:0]  mapped;
    logic        active;
    t_group      grp;

    assign move            = r_s1_valid && i_take_ok;
    assign i_char_if.ready = !r_s1_valid || i_take_ok;
    assign mapped          = map_char(r_char);
    assign active          = !r_pad && !r_err;

    always_comb begin
        n_sext      = r_sext;
        n_gcnt      = r_gcnt;
        n_len       = r_len + 2'd1;
        n_pad       = r_pad;
        n_err       = r_err;
        grp.bytes   = '0;
        grp.cnt     = 2'd0;
        grp.bval    = 1'b1;
        grp.fin     = r_last;
        grp.status  = ST_OK;

        if (active) begin
            if (r_char == PAD_CHAR) begin
                n_pad = 1'b1;
            end else if (!mapped[6]) begin
                n_err = 1'b1;
            end else if (r_gcnt == 2'd3) begin
                grp.bytes[0] = r_sext[17:10];
                grp.bytes[1] = {r_sext[9:4], 2'b00} | 8'(r_sext[3:0] >> 2);
                grp.bytes[2] = {r_sext[1:0], mapped[5:0]};
                grp.cnt      = 2'd3;
                n_sext       = '0;
                n_gcnt       = 2'd0;
            end else begin
                n_sext = {r_sext[11:0], mapped[5:0]};
                n_gcnt = r_gcnt + 2'd1;
            end
        end

        if (r_last) begin
            if (n_len != 2'd0) begin
                grp.status = ST_BAD_LEN;
            end else if (n_err) begin
                grp.status = ST_BAD_CHAR;
            end

            if (grp.status != ST_OK) begin
                grp.bytes = '0;
                grp.cnt   = 2'd1;
                grp.bval  = 1'b0;
            end else if (n_gcnt == 2'd2) begin
                grp.bytes[0] = n_sext[11:4];
                grp.cnt      = 2'd1;
            end else if (n_gcnt == 2'd3) begin
                grp.bytes[0] = n_sext[17:10];
                grp.bytes[1] = n_sext[9:2];
                grp.cnt      = 2'd2;
            end else if (grp.cnt == 2'd0) begin
                // final item with nothing to show: one empty closing result
                grp.cnt  = 2'd1;
                grp.bval = 1'b0;
            end
        end
    end

    assign o_group = grp;
    assign o_load  = move && (grp.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_char_if.valid && i_char_if.ready) begin
            r_s1_valid <= 1'b1;
        end else if (move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char_if.valid && i_char_if.ready) begin
            r_char <= i_char_if.in_char;
            r_last <= i_char_if.in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sext <= '0;
            r_gcnt <= 2'd0;
            r_len  <= 2'd0;
            r_pad  <= 1'b0;
            r_err  <= 1'b0;
        end else if (move) begin
            if (r_last) begin
                // end of text: start the next one clean
                r_sext <= '0;
                r_gcnt <= 2'd0;
                r_len  <= 2'd0;
                r_pad  <= 1'b0;
                r_err  <= 1'b0;
            end else begin
                r_sext <= n_sext;
                r_gcnt <= n_gcnt;
                r_len  <= n_len;
                r_pad  <= n_pad;
                r_err  <= n_err;
            end
        end
    end

endmodule

@@ rtl/core/b64_ser.sv @@
// Result group register and serializer onto the byte output channel.
module b64_ser
    import b64_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_group       i_group,
    output logic         o_take_ok,
    b64_out_if.source    o_byte_if
);

    logic [2:0][7:0] r_bytes;
    logic [1:0]      r_cnt;
    logic [1:0]      r_idx;
    logic            r_bval;
    logic            r_fin;
    t_status         r_status;

    logic            at_end;
    logic            fire;

    assign at_end    = (r_idx == (r_cnt - 2'd1));
    assign fire      = o_byte_if.valid && o_byte_if.ready;
    assign o_take_ok = (r_cnt == 2'd0) || (fire && at_end);

    assign o_byte_if.valid      = (r_cnt != 2'd0);
    assign o_byte_if.out_byte   = r_bval ? r_bytes[r_idx] : 8'd0;
    assign o_byte_if.byte_valid = r_bval;
    assign o_byte_if.out_last   = r_fin && at_end;
    assign o_byte_if.status     = (r_fin && at_end) ? r_status : ST_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_group.cnt;
            r_idx <= 2'd0;
        end else if (fire) begin
            if (at_end) begin
                r_cnt <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes  <= i_group.bytes;
            r_bval   <= i_group.bval;
            r_fin    <= i_group.fin;
            r_status <= i_group.status;
        end
    end

endmodule

@@ rtl/core/base64_stream_decoder.sv @@
// Top level of the Base64 stream decoder.
// The first result of an item passes the input register, then the result register,
//   which takes it once empty or while its last result is taken.
// Throughput: one item per cycle while the output is ready; an item that yields several
//   results holds the input while the result register drains them, one per cycle when ready.
// Reset (synchronous, active low) empties both registers and clears the
//   decode state; no clearing pass is needed.
module base64_stream_decoder
    import b64_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    b64_in_if.sink    i_char_if,
    b64_out_if.source o_byte_if
);

    logic   take_ok;
    logic   load;
    t_group group;

    b64_dec u_dec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char_if (i_char_if),
        .i_take_ok (take_ok),
        .o_load    (load),
        .o_group   (group)
    );

    b64_ser u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_group   (group),
        .o_take_ok (take_ok),
        .o_byte_if (o_byte_if)
    );

endmodule

@@ rtl/core/b64_chk.sv @@
// Port-level checks on the decoder output, bound to the top level.
module b64_chk
    import b64_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_byte,
    input logic       i_byte_valid,
    input logic       i_last,
    input logic [1:0] i_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_byte) && $stable(i_last))
        else $error("output item changed while stalled");

    a_empty_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_byte_valid |-> i_last && (i_byte == 8'd0))
        else $error("empty result that is not the closing one");

    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != ST_OK) |-> i_last && !i_byte_valid)
        else $error("error status off the closing result or with a byte");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_status == ST_OK) || (i_status == ST_BAD_CHAR)
                    || (i_status == ST_BAD_LEN))
        else $error("undefined status code");

endmodule

bind base64_stream_decoder b64_chk u_b64_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_byte_if.valid),
    .i_ready      (o_byte_if.ready),
    .i_byte       (o_byte_if.out_byte),
    .i_byte_valid (o_byte_if.byte_valid),
    .i_last       (o_byte_if.out_last),
    .i_status     (o_byte_if.status)
);

@@ sim/tb_base64_stream_decoder.sv @@
// Testbench of the Base64 stream decoder: sends character texts and checks the decoded bytes.

// One expected byte result
typedef struct packed {
    logic [7:0]       data;
    logic             bval;
    logic             fin;
    b64_pkg::t_status st;
} t_dec_byte;

class b64_scoreboard;
    bit [17:0] sextets;
    bit [1:0]  n_sextets;
    bit [1:0]  len_mod4;
    bit        pad_hit;
    bit        bad_hit;
    t_dec_byte expected_bytes[$];
    int        errors;

    function int sextet_of(logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c - "A");
        if (c >= "a" && c <= "z") return int'(c - "a") + 26;
        if (c >= "0" && c <= "9") return int'(c - "0") + 52;
        if (c == "+") return 62;
        if (c == "/") return 63;
        return -1;
    endfunction

    // Predict the bytes that one accepted character yields
    function void note_char(logic [7:0] c, logic last);
        t_dec_byte        res[3];
        int               k;
        int               v;
        bit [23:0]        word;
        b64_pkg::t_status st;
        k = 0;
        len_mod4 = len_mod4 + 2'd1;
        if (!pad_hit && !bad_hit) begin
            if (c == b64_pkg::PAD_CHAR) begin
                pad_hit = 1'b1;
            end else begin
                v = sextet_of(c);
                if (v < 0) begin
                    bad_hit = 1'b1;
                end else if (n_sextets == 2'd3) begin
                    word = {sextets, v[5:0]};
                    res[0] = '{word[23:16], 1'b1, 1'b0, b64_pkg::ST_OK};
                    res[1] = '{word[15:8], 1'b1, 1'b0, b64_pkg::ST_OK};
                    res[2] = '{word[7:0], 1'b1, 1'b0, b64_pkg::ST_OK};
                    k = 3;
                    sextets = '0;
                    n_sextets = '0;
                end else begin
                    sextets = {sextets[11:0], v[5:0]};
                    n_sextets = n_sextets + 2'd1;
                end
            end
        end
        if (last) begin
            if (len_mod4 != 2'd0) st = b64_pkg::ST_BAD_LEN;
            else if (bad_hit) st = b64_pkg::ST_BAD_CHAR;
            else st = b64_pkg::ST_OK;
            if (st != b64_pkg::ST_OK) begin
                // drop any group bytes of this item, report status only
                res[0] = '{8'h00, 1'b0, 1'b1, st};
                k = 1;
            end else begin
                if (n_sextets == 2'd2) begin
                    res[k] = '{sextets[11:4], 1'b1, 1'b0, b64_pkg::ST_OK};
                    k++;
                end else if (n_sextets == 2'd3) begin
                    res[k] = '{sextets[17:10], 1'b1, 1'b0, b64_pkg::ST_OK};
                    res[k + 1] = '{sextets[9:2], 1'b1, 1'b0, b64_pkg::ST_OK};
                    k += 2;
                end
                if (k == 0) begin
                    res[0] = '{8'h00, 1'b0, 1'b1, b64_pkg::ST_OK};
                    k = 1;
                end else begin
                    res[k - 1].fin = 1'b1;
                end
            end
            sextets = '0;
            n_sextets = '0;
            len_mod4 = '0;
            pad_hit = 1'b0;
            bad_hit = 1'b0;
        end
        for (int i = 0; i < k; i++) expected_bytes.push_back(res[i]);
    endfunction

    function void check_byte(logic [7:0] data, logic bval, logic fin, logic [1:0] st,
                             time now);
        t_dec_byte want;
        if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte %02h valid %0b last %0b status %0d",
                     now, data, bval, fin, st);
            errors++;
            return;
        end
        want = expected_bytes.pop_front();
        if (data !== want.data) begin
            $display("%0t: out_byte expected %02h, got %02h", now, want.data, data);
            errors++;
        end
        if (bval !== want.bval) begin
            $display("%0t: byte_valid expected %0b, got %0b", now, want.bval, bval);
            errors++;
        end
        if (fin !== want.fin) begin
            $display("%0t: out_last expected %0b, got %0b", now, want.fin, fin);
            errors++;
        end
        if (st !== want.st) begin
            $display("%0t: status expected %0d, got %0d", now, want.st, st);
            errors++;
        end
    endfunction
endclass

module tb_base64_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import b64_pkg::*;

    logic i_clk;
    logic i_rst_n;

    b64_in_if  in_ch();
    b64_out_if out_ch();

    base64_stream_decoder i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char_if (in_ch),
        .o_byte_if (out_ch)
    );

    b64_scoreboard sb;
    string alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    int    burst_left;
    int    items_sent;
    int    calm_left;
    int    stall_left;
    bit    calm;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: calm stretches and stretches of random stalls, chosen at random
    always @(negedge i_clk) begin
        if (calm_left == 0) begin
            calm_left = $urandom_range(20, 80);
            calm = ($urandom_range(0, 2) == 0);
        end
        calm_left--;
        if (calm) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_byte(out_ch.out_byte, out_ch.byte_valid, out_ch.out_last,
                          out_ch.status, $time);
        end
    end

    function automatic logic [7:0] rand_sym();
        return alpha[$urandom_range(0, 63)];
    endfunction

    // Called and returns at a falling edge; holds valid through a burst
    task automatic send_char(input logic [7:0] c, input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_char <= c;
        in_ch.in_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_char(c, last);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_text(input logic [7:0] txt[$]);
        for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic send_str(input string s);
        logic [7:0] txt[$];
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        send_text(txt);
    endtask

    initial begin
        logic [7:0] txt[$];
        int         kind;
        int         groups;
        int         n;
        sb = new();
        in_ch.valid   = 1'b0;
        in_ch.in_char = 8'h00;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;
        burst_left    = 0;
        items_sent    = 0;
        calm_left     = 0;
        stall_left    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full groups, three leftover values, dropped single value
        send_str("TWFu");
        send_str("TWE=");
        send_str("A===");
        send_str("AZaz09+/");
        // bad characters at both ends of the byte range with a bad length, then one in a text of good length
        txt = {8'h00, "B", 8'hFF};
        send_text(txt);
        send_str("Q!xy");

        while (items_sent < 360) begin
            txt.delete();
            kind = $urandom_range(0, 9);
            if (kind <= 7) begin
                groups = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12)
                                                      : $urandom_range(0, 3);
                repeat (groups * 4) txt.push_back(rand_sym());
                case ($urandom_range(0, 4))
                    1: txt = {txt, rand_sym(), rand_sym(), "=", "="};
                    2: txt = {txt, rand_sym(), rand_sym(), rand_sym(), "="};
                    3: repeat ($urandom_range(1, 3)) txt.push_back(rand_sym());
                    4: txt = {txt, rand_sym(), "=", "=", "="};
                    default: ;
                endcase
                if (txt.size() == 0) txt = {rand_sym(), rand_sym(), "=", "="};
                // break the text: corrupt one character or cut the tail
                if (kind == 7) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
                if (kind == 6 && txt.size() > 1) void'(txt.pop_back());
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 9)) begin
                    case ($urandom_range(0, 3))
                        0: txt.push_back(8'($urandom_range(0, 255)));
                        1: txt.push_back(PAD_CHAR);
                        default: txt.push_back(rand_sym());
                    endcase
                end
            end else begin
                // early padding, then characters that are only counted
                repeat ($urandom_range(1, 3)) txt.push_back(rand_sym());
                txt.push_back(PAD_CHAR);
                n = ($urandom_range(0, 3) == 0) ? txt.size() + $urandom_range(0, 5)
                                                : 4 * $urandom_range(1, 3);
                while (txt.size() < n) begin
                    txt.push_back($urandom_range(0, 1) ? rand_sym() : 8'($urandom_range(0, 255)));
                end
            end
            send_text(txt);
        end
        in_ch.valid <= 1'b0;

        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
